[src/sff_pkg.sv]
// Package for the stereo FIR filter core: sizes, item codes, MAC control
// and the output rounding function. No dependencies.
package sff_pkg;

  localparam int TAPS        = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int ADDR_W      = $clog2(TAPS);
  localparam int CNT_W       = $clog2(TAPS + 1);
  localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W       = PROD_W + ADDR_W;

  // item function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // MAC control from the sequencer
  typedef struct packed {
    logic clr;  // start a new sum
    logic vld;  // coefficient/sample pair present this cycle
  } mac_ctl_t;

  // Shift right by COEF_BITS-1, round half up, saturate to SAMPLE_BITS
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W:0] sum;
    logic signed [ACC_W:0] q;
    logic signed [ACC_W:0] hi;
    logic signed [ACC_W:0] lo;
    sum = (ACC_W+1)'(acc) + ((ACC_W+1)'(1) <<< (COEF_BITS - 2));
    q   = sum >>> (COEF_BITS - 1);
    hi  = (ACC_W+1)'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    lo  = -hi - (ACC_W+1)'(1);
    if (q > hi) begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (q < lo) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return q[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

[src/sff_if.sv]
// Channel interfaces for the stereo FIR filter core: input item and result item.
// Depends on sff_pkg.
interface sff_in_if;
  import sff_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [7:0]                    coef_index;
  logic signed [COEF_BITS-1:0]   coef_left;
  logic signed [COEF_BITS-1:0]   coef_right;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;

  modport source (output valid, func, coef_index, coef_left, coef_right,
                  sample_left, sample_right, input ready);
  modport sink   (input valid, func, coef_index, coef_left, coef_right,
                  sample_left, sample_right, output ready);
endinterface

interface sff_out_if;
  import sff_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  modport source (output valid, out_left, out_right, input ready);
  modport sink   (input valid, out_left, out_right, output ready);
endinterface

[src/sff_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sff_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/sff_mac.sv]
// One channel's multiply-accumulate unit: registered product, then accumulator.
// Depends on sff_pkg.
module sff_mac
  import sff_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  mac_ctl_t                      ctl,
  input  logic signed [COEF_BITS-1:0]   coef,
  input  logic signed [SAMPLE_BITS-1:0] smp,
  output logic                          busy,
  output logic signed [ACC_W-1:0]       acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  logic signed [ACC_W-1:0]  acc_r;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.vld;
    end
    prod_r <= coef * smp;
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign busy = prod_v_r;
  assign acc  = acc_r;

endmodule

[src/stereo_fir_filter_core.sv]
// Stereo FIR filter core, top level.
// Depends on sff_pkg, sff_in_if/sff_out_if, sff_ram and sff_mac.
//
// Usage:
//   in_ch carries items: func=0 loads a left/right coefficient pair at
//   coef_index (no result, ready stays high); func=1
//   carries a stereo sample pair and yields one filtered pair on out_ch.
//   Load all coefficients before sending samples.
//   A sample item runs from acceptance to the result register through one MAC
//   per channel, one tap per cycle, fed by one read port of the coefficient
//   RAM and one of the sample history RAM, plus the RAM read, product and
//   final rounding stages. in_ch.ready is low meanwhile, so no new sample
//   pair is taken until its result has been registered.
//   The result sits in an output register; the next item may be accepted while
//   it waits. If out_ch stalls when the next result is done, the core holds
//   in its final state until the register frees up.
//   Reset (rst_n low, synchronous) empties the sample history, so samples
//   before the first one count as zero; coefficients are not cleared.
module stereo_fir_filter_core
  import sff_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  sff_in_if.sink    in_ch,
  sff_out_if.source out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  wptr_r, wptr_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic               s1_v_r, s1_ok_r;
  logic               out_v_r, out_v_nxt;
  logic signed [SAMPLE_BITS-1:0] out_l_r, out_r_r;

  logic               in_acc, load_acc, smp_acc, load_ok, done;
  logic [2*COEF_BITS-1:0]   coef_rd;
  logic [2*SAMPLE_BITS-1:0] hist_rd;
  logic signed [SAMPLE_BITS-1:0] smp_l, smp_r;
  logic signed [ACC_W-1:0] acc_l, acc_r;
  logic               busy_l, busy_r;
  mac_ctl_t           mac_ctl;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign load_acc = in_acc && (in_ch.func == FUNC_LOAD);
  assign smp_acc  = in_acc && (in_ch.func == FUNC_SAMPLE);
  assign load_ok  = 32'(in_ch.coef_index) < TAPS;
  assign done     = (state_r == ST_DRAIN) && !s1_v_r && !busy_l && !busy_r
                    && (!out_v_r || out_ch.ready);

  // coefficient store, left in the upper half
  sff_ram #(.WIDTH(2*COEF_BITS), .DEPTH(TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (load_acc && load_ok),
    .waddr (ADDR_W'(in_ch.coef_index)),
    .wdata ({in_ch.coef_left, in_ch.coef_right}),
    .raddr (k_r[ADDR_W-1:0]),
    .rdata (coef_rd)
  );

  // circular sample history, newest at base_r
  sff_ram #(.WIDTH(2*SAMPLE_BITS), .DEPTH(TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (smp_acc),
    .waddr (wptr_r),
    .wdata ({in_ch.sample_left, in_ch.sample_right}),
    .raddr (base_r - k_r[ADDR_W-1:0]),
    .rdata (hist_rd)
  );

  // samples older than the first one after reset read as zero
  assign smp_l = s1_ok_r ? hist_rd[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
  assign smp_r = s1_ok_r ? hist_rd[SAMPLE_BITS-1:0] : '0;

  assign mac_ctl.clr = smp_acc;
  assign mac_ctl.vld = s1_v_r;

  sff_mac u_mac_l (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coef  (coef_rd[2*COEF_BITS-1:COEF_BITS]),
    .smp   (smp_l),
    .busy  (busy_l),
    .acc   (acc_l)
  );

  sff_mac u_mac_r (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coef  (coef_rd[COEF_BITS-1:0]),
    .smp   (smp_r),
    .busy  (busy_r),
    .acc   (acc_r)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    wptr_nxt  = wptr_r;
    base_nxt  = base_r;
    out_v_nxt = out_v_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (smp_acc) begin
          base_nxt  = wptr_r;
          wptr_nxt  = wptr_r + ADDR_W'(1);
          cnt_nxt   = (cnt_r == CNT_W'(TAPS)) ? cnt_r : cnt_r + CNT_W'(1);
          k_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        k_nxt = k_r + CNT_W'(1);
        if (k_r == CNT_W'(TAPS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done) begin
          out_v_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      cnt_r   <= '0;
      wptr_r  <= '0;
      base_r  <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
      wptr_r  <= wptr_nxt;
      base_r  <= base_nxt;
      s1_v_r  <= (state_r == ST_RUN);
      out_v_r <= out_v_nxt;
    end
    s1_ok_r <= k_r < cnt_r;
    if (done) begin
      out_l_r <= round_sat(acc_l);
      out_r_r <= round_sat(acc_r);
    end
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_v_r;
  assign out_ch.out_left  = out_l_r;
  assign out_ch.out_right = out_r_r;

`ifndef ASSERT_OFF
  // an accepted sample always starts the tap sweep
  a_smp_starts: assert property (@(posedge clk) disable iff (!rst_n)
    smp_acc |=> state_r == ST_RUN)
    else $error("sample item did not start the tap sweep");

  // history fill count never passes the tap count
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TAPS))
    else $error("history count out of range");

  // no MAC work in flight while the core is idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !s1_v_r && !busy_l && !busy_r)
    else $error("MAC pipeline busy while idle");

  // a new result appears only at the end of the drain
  a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r) == ST_DRAIN)
    else $error("result raised outside drain");
`endif

endmodule
